// ===== design/slt_pkg.sv =====
package slt_pkg;

  // Coordinate format and fixed widths
  localparam int COORD_WIDTH_DEF = 24;
  localparam int COORD_FRAC      = 12;
  localparam int CFG_DATA_W      = 48;
  localparam int CFG_IDX_W       = 3;

  // Reduced vector magnitude used for the direction cosine
  localparam int E_WIDTH = 30;

  // Q1.14 unity and the color scale shift
  localparam int ONE_Q14     = 16384;
  localparam int COLOR_SHIFT = 2 * COORD_FRAC - 14;

  // Quotient widths of the three divider kinds; the ramp reaches 1.0 itself
  localparam int COS_QW  = 18;
  localparam int RAMP_QW = 15;
  localparam int CH_QW   = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIGHT_X     = 3'd0,
    CFG_LIGHT_Y     = 3'd1,
    CFG_LIGHT_Z     = 3'd2,
    CFG_SPOT_AXIS   = 3'd3,
    CFG_INNER_COS   = 3'd4,
    CFG_OUTER_COS   = 3'd5,
    CFG_LIGHT_COLOR = 3'd6
  } cfg_idx_t;

endpackage

// ===== design/slt_pipe.sv =====
module slt_pipe
  import slt_pkg::*;
#(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  logic [WIDTH-1:0] in_d,
  output logic             out_v,
  output logic [WIDTH-1:0] out_d
);

  logic             v_r [DEPTH];
  logic [WIDTH-1:0] d_r [DEPTH];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
      for (int k = 1; k < DEPTH; k++) v_r[k] <= v_r[k-1];
    end
  end

  // Advance payload alongside
  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= in_d;
      for (int k = 1; k < DEPTH; k++) d_r[k] <= d_r[k-1];
    end
  end

  assign out_v = v_r[DEPTH-1];
  assign out_d = d_r[DEPTH-1];

endmodule

// ===== design/slt_isqrt.sv =====
module slt_isqrt
  import slt_pkg::*;
#(
  parameter int NW = 2 * E_WIDTH + 2
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NW-1:0]   n_i,
  output logic [NW/2-1:0] root_o
);

  localparam int STEPS = NW / 2;

  logic [NW-1:0] n_r [STEPS];
  logic [NW-1:0] r_r [STEPS];

  // One root bit per stage, from the top pair of bits down
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [NW-1:0] BIT = NW'(1) << (NW - 2 - 2 * k);
    logic [NW-1:0] n_in;
    logic [NW-1:0] r_in;
    logic [NW-1:0] rb;

    if (k == 0) begin : g_first
      assign n_in = n_i;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = n_r[k-1];
      assign r_in = r_r[k-1];
    end

    assign rb = r_in + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (n_in >= rb) begin
          n_r[k] <= n_in - rb;
          r_r[k] <= (r_in >> 1) + BIT;
        end else begin
          n_r[k] <= n_in;
          r_r[k] <= r_in >> 1;
        end
      end
    end
  end

  assign root_o = r_r[STEPS-1][NW/2-1:0];

endmodule

// ===== design/slt_div.sv =====
module slt_div
  import slt_pkg::*;
#(
  parameter int NW = 48,
  parameter int DW = 31,
  parameter int QW = COS_QW
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] q_o
);

  // Numerator must stay below the divisor shifted by QW
  localparam int RW = (NW > DW + QW) ? NW : DW + QW;

  logic [RW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] q_r   [QW];

  // Restoring division, one quotient bit per stage, MSB first
  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int POS = QW - 1 - k;
    logic [RW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in;
    logic [RW-1:0] dsh;

    if (k == 0) begin : g_first
      assign rem_in = RW'(num_i);
      assign den_in = den_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign dsh = RW'(den_in) << POS;

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_in;
        if (rem_in >= dsh) begin
          rem_r[k] <= rem_in - dsh;
          q_r[k]   <= q_in | (QW'(1) << POS);
        end else begin
          rem_r[k] <= rem_in;
          q_r[k]   <= q_in;
        end
      end
    end
  end

  assign q_o = q_r[QW-1];

endmodule

// ===== design/spot_light_intensity.sv =====
// Spotlight intensity pipeline: one surface point per cycle when out_stall stays low.
// Pipeline stages: five front stages, 31 square-root stages, 18 + 15 + 16 divider stages,
// three glue stages and the output register.
// A two-entry output buffer lets the pipeline take a new point while a result waits.
// Reset (rst_n low, synchronous) empties the pipeline and buffer and loads the register
// defaults: light at origin, zero axis and color, inner cosine one, outer cosine zero.
module spot_light_intensity
  import slt_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   out_red_out,
  output logic [15:0]                   out_green_out,
  output logic [15:0]                   out_blue_out,
  output logic [14:0]                   out_cone_weight,
  output logic                          out_lit,
  output logic                          out_too_close,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int W     = COORD_WIDTH;
  localparam int SUMW  = (2 * W + 2 > 65) ? 2 * W + 2 : 65;
  localparam int EW    = E_WIDTH;
  localparam int ESQW  = 2 * EW + 2;
  localparam int LENW  = ESQW / 2;
  localparam int PW    = EW + 1 + 16;
  localparam int DOTW  = PW + 2;
  localparam int DMW   = DOTW - 1;
  localparam int CW    = COS_QW + 1;
  localparam int RDW   = 16;
  localparam int RNW   = RDW + RAMP_QW;
  localparam int NUMW  = 16 + 15 + COLOR_SHIFT;
  localparam int SATW  = 64 + CH_QW;

  typedef enum logic [1:0] {SEL_ZERO, SEL_PART, SEL_FULL} sel_t;

  typedef struct packed {
    logic           dot_neg;
    logic [DMW-1:0] dot_mag;
    logic [63:0]    lo;
    logic           hi_nz;
    logic           close;
  } sb_a_t;

  typedef struct packed {
    logic        dot_neg;
    logic [63:0] lo;
    logic        hi_nz;
    logic        close;
  } sb_b_t;

  typedef struct packed {
    sel_t        sel;
    logic [63:0] lo;
    logic        hi_nz;
    logic        close;
  } sb_c_t;

  typedef struct packed {
    logic [2:0]  sat;
    logic [14:0] w;
    logic        hi_nz;
    logic        close;
  } sb_d_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [14:0] cone;
    logic        lit;
    logic        close;
  } res_t;

  // Configuration registers
  logic [W-1:0]  light_x_r, light_y_r, light_z_r;
  logic [47:0]   spot_axis_r, light_color_r;
  logic [15:0]   inner_cos_r, outer_cos_r;

  logic en;
  logic skid_v_r, out_v_r;
  res_t skid_d_r, out_d_r, tail;

  assign cfg_ready = 1'b1;

  // Take register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_x_r     <= '0;
      light_y_r     <= '0;
      light_z_r     <= '0;
      spot_axis_r   <= '0;
      inner_cos_r   <= 16'(ONE_Q14);
      outer_cos_r   <= '0;
      light_color_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LIGHT_X:     light_x_r     <= cfg_data[W-1:0];
        CFG_LIGHT_Y:     light_y_r     <= cfg_data[W-1:0];
        CFG_LIGHT_Z:     light_z_r     <= cfg_data[W-1:0];
        CFG_SPOT_AXIS:   spot_axis_r   <= cfg_data[47:0];
        CFG_INNER_COS:   inner_cos_r   <= cfg_data[15:0];
        CFG_OUTER_COS:   outer_cos_r   <= cfg_data[15:0];
        CFG_LIGHT_COLOR: light_color_r <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances while the output buffer has room
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  logic [W-1:0] pt [3];
  logic [W-1:0] lt [3];
  assign pt[0] = in_point_x;
  assign pt[1] = in_point_y;
  assign pt[2] = in_point_z;
  assign lt[0] = light_x_r;
  assign lt[1] = light_y_r;
  assign lt[2] = light_z_r;

  // Stage 1: point minus light
  logic       v1_r;
  logic [W:0] d_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) d_r[i] <= {pt[i][W-1], pt[i]} - {lt[i][W-1], lt[i]};
    end
  end

  // Stage 2: magnitudes and signs
  logic         v2_r;
  logic [W-1:0] m_nxt [3];
  logic [W-1:0] m_r   [3];
  logic         neg2_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) m_nxt[i] = d_r[i][W] ? W'(-d_r[i]) : W'(d_r[i]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_r[i]    <= m_nxt[i];
        neg2_r[i] <= d_r[i][W];
      end
    end
  end

  // Stage 3: full squares and reduced components
  logic            v3_r;
  logic [1:0]      sh;
  logic            fits;
  logic [2*W-1:0]  sq_nxt [3];
  logic [EW-1:0]   em_nxt [3];
  logic [2*W-1:0]  sq_r   [3];
  logic [EW-1:0]   em_r   [3];
  logic            neg3_r [3];

  always_comb begin
    sh = 2'd0;
    for (int k = 3; k >= 0; k--) begin
      fits = 1'b1;
      for (int i = 0; i < 3; i++) begin
        if (((32'(m_r[i]) >> k) >> EW) != 32'd0) fits = 1'b0;
      end
      if (fits) sh = 2'(k);
    end
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = (2*W)'(m_r[i]) * (2*W)'(m_r[i]);
      em_nxt[i] = EW'(32'(m_r[i]) >> sh);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i]   <= sq_nxt[i];
        em_r[i]   <= em_nxt[i];
        neg3_r[i] <= neg2_r[i];
      end
    end
  end

  // Stage 4: distance sum, reduced squares, axis products
  logic                   v4_r;
  logic [SUMW-1:0]        full_r;
  logic signed [EW:0]     e_s      [3];
  logic [2*EW-1:0]        esq_nxt  [3];
  logic signed [PW-1:0]   prod_nxt [3];
  logic [2*EW-1:0]        esq_r    [3];
  logic signed [PW-1:0]   prod_r   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_s[i]      = neg3_r[i] ? -$signed({1'b0, em_r[i]}) : $signed({1'b0, em_r[i]});
      esq_nxt[i]  = (2*EW)'(em_r[i]) * (2*EW)'(em_r[i]);
      prod_nxt[i] = PW'($signed(spot_axis_r[16*i +: 16])) * PW'(e_s[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      full_r <= SUMW'(sq_r[0]) + SUMW'(sq_r[1]) + SUMW'(sq_r[2]);
      for (int i = 0; i < 3; i++) begin
        esq_r[i]  <= esq_nxt[i];
        prod_r[i] <= prod_nxt[i];
      end
    end
  end

  // Stage 5: reduced length squared and dot product
  logic                   v5_r;
  logic [ESQW-1:0]        esum_r;
  logic signed [DOTW-1:0] dot_r;
  logic [63:0]            lo5_r;
  logic                   hinz5_r, close5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      esum_r   <= ESQW'(esq_r[0]) + ESQW'(esq_r[1]) + ESQW'(esq_r[2]);
      dot_r    <= DOTW'(prod_r[0]) + DOTW'(prod_r[1]) + DOTW'(prod_r[2]);
      lo5_r    <= full_r[63:0];
      hinz5_r  <= |full_r[SUMW-1:64];
      close5_r <= (full_r == '0);
    end
  end

  // Front valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Length by square root, sideband held alongside
  logic [LENW-1:0] len;
  sb_a_t           sba_in, sba;
  logic            va;

  assign sba_in.dot_neg = dot_r[DOTW-1];
  assign sba_in.dot_mag = dot_r[DOTW-1] ? DMW'(-dot_r) : DMW'(dot_r);
  assign sba_in.lo      = lo5_r;
  assign sba_in.hi_nz   = hinz5_r;
  assign sba_in.close   = close5_r;

  slt_isqrt #(.NW(ESQW)) u_isqrt (
    .clk    (clk),
    .en     (en),
    .n_i    (esum_r),
    .root_o (len)
  );

  slt_pipe #(.WIDTH($bits(sb_a_t)), .DEPTH(LENW)) u_pipe_a (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (v5_r),
    .in_d  (sba_in),
    .out_v (va),
    .out_d (sba)
  );

  // Cosine magnitude by division
  logic [COS_QW-1:0] q_cos;
  logic [LENW-1:0]   len_nz;
  sb_b_t             sbb_in, sbb;
  logic              vb;

  assign len_nz         = (len == '0) ? LENW'(1) : len;
  assign sbb_in.dot_neg = sba.dot_neg;
  assign sbb_in.lo      = sba.lo;
  assign sbb_in.hi_nz   = sba.hi_nz;
  assign sbb_in.close   = sba.close;

  slt_div #(.NW(DMW), .DW(LENW), .QW(COS_QW)) u_div_cos (
    .clk   (clk),
    .en    (en),
    .num_i (sba.dot_mag),
    .den_i (len_nz),
    .q_o   (q_cos)
  );

  slt_pipe #(.WIDTH($bits(sb_b_t)), .DEPTH(COS_QW)) u_pipe_b (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (va),
    .in_d  (sbb_in),
    .out_v (vb),
    .out_d (sbb)
  );

  // Cone compare and ramp operands
  logic signed [CW-1:0] cosv, ci_x, co_x, diff_c;
  logic signed [16:0]   dden;
  logic                 is_full, is_part;
  sel_t                 sel_nxt;
  logic [RNW-1:0]       rnum_nxt;
  logic [RDW-1:0]       rden_nxt;

  always_comb begin
    cosv    = sbb.dot_neg ? -$signed({1'b0, q_cos}) : $signed({1'b0, q_cos});
    ci_x    = CW'($signed(inner_cos_r));
    co_x    = CW'($signed(outer_cos_r));
    diff_c  = cosv - co_x;
    dden    = {inner_cos_r[15], inner_cos_r} - {outer_cos_r[15], outer_cos_r};
    is_full = cosv > ci_x;
    is_part = !is_full && (cosv > co_x);
    if (is_full) begin
      sel_nxt = SEL_FULL;
    end else if (is_part) begin
      sel_nxt = SEL_PART;
    end else begin
      sel_nxt = SEL_ZERO;
    end
    rnum_nxt = is_part ? (RNW'(diff_c[RDW-1:0]) << (RAMP_QW - 1)) : '0;
    rden_nxt = is_part ? dden[RDW-1:0] : RDW'(1);
  end

  logic           vr_r;
  logic [RNW-1:0] rnum_r;
  logic [RDW-1:0] rden_r;
  sb_c_t          sbc_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vr_r <= 1'b0;
    end else if (en) begin
      vr_r <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnum_r       <= rnum_nxt;
      rden_r       <= rden_nxt;
      sbc_in.sel   <= sel_nxt;
      sbc_in.lo    <= sbb.lo;
      sbc_in.hi_nz <= sbb.hi_nz;
      sbc_in.close <= sbb.close;
    end
  end

  // Ramp weight by division
  logic [RAMP_QW-1:0] q_ramp;
  sb_c_t              sbc;
  logic               vc;

  slt_div #(.NW(RNW), .DW(RDW), .QW(RAMP_QW)) u_div_ramp (
    .clk   (clk),
    .en    (en),
    .num_i (rnum_r),
    .den_i (rden_r),
    .q_o   (q_ramp)
  );

  slt_pipe #(.WIDTH($bits(sb_c_t)), .DEPTH(RAMP_QW)) u_pipe_c (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (vr_r),
    .in_d  (sbc_in),
    .out_v (vc),
    .out_d (sbc)
  );

  // Cone weight
  logic [14:0] w_nxt, w_r;
  logic        vw_r, hinzw_r, closew_r;
  logic [63:0] low_r;

  always_comb begin
    if (sbc.close) begin
      w_nxt = 15'(ONE_Q14);
    end else begin
      case (sbc.sel)
        SEL_FULL: w_nxt = 15'(ONE_Q14);
        SEL_PART: w_nxt = 15'(q_ramp);
        default:  w_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vw_r <= 1'b0;
    end else if (en) begin
      vw_r <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r      <= w_nxt;
      low_r    <= sbc.lo;
      hinzw_r  <= sbc.hi_nz;
      closew_r <= sbc.close;
    end
  end

  // Scaled color numerators
  logic [NUMW-1:0] num_r [3];
  logic [14:0]     wm_r;
  logic [63:0]     lom_r;
  logic            vm_r, hinzm_r, closem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (en) begin
      vm_r <= vw_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= (NUMW'(light_color_r[16*i +: 16]) * NUMW'(w_r)) << COLOR_SHIFT;
      end
      wm_r     <= w_r;
      lom_r    <= low_r;
      hinzm_r  <= hinzw_r;
      closem_r <= closew_r;
    end
  end

  // Channel division by squared distance; saturate up front
  logic [2:0]       sat;
  logic [NUMW-1:0]  ch_num [3];
  logic [CH_QW-1:0] q_ch   [3];
  sb_d_t            sbd_in, sbd;
  logic             vd;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat[i]    = SATW'(num_r[i]) >= (SATW'(lom_r) << CH_QW);
      ch_num[i] = sat[i] ? '0 : num_r[i];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_ch
    slt_div #(.NW(NUMW), .DW(64), .QW(CH_QW)) u_div_ch (
      .clk   (clk),
      .en    (en),
      .num_i (ch_num[i]),
      .den_i (lom_r),
      .q_o   (q_ch[i])
    );
  end

  assign sbd_in.sat   = sat;
  assign sbd_in.w     = wm_r;
  assign sbd_in.hi_nz = hinzm_r;
  assign sbd_in.close = closem_r;

  slt_pipe #(.WIDTH($bits(sb_d_t)), .DEPTH(CH_QW)) u_pipe_d (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (vm_r),
    .in_d  (sbd_in),
    .out_v (vd),
    .out_d (sbd)
  );

  // Final channel selection
  logic [15:0] ch_res [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sbd.close) begin
        ch_res[i] = (light_color_r[16*i +: 16] != 16'd0) ? 16'hFFFF : 16'd0;
      end else if (sbd.hi_nz) begin
        ch_res[i] = 16'd0;
      end else if (sbd.sat[i]) begin
        ch_res[i] = 16'hFFFF;
      end else begin
        ch_res[i] = q_ch[i];
      end
    end
    tail.red   = ch_res[0];
    tail.green = ch_res[1];
    tail.blue  = ch_res[2];
    tail.cone  = sbd.w;
    tail.lit   = (sbd.w != '0);
    tail.close = sbd.close;
  end

  // Output register with skid entry: hold while stalled, park one transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= vd;
      end
    end else if (vd && !skid_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || !out_stall) begin
      out_d_r <= skid_v_r ? skid_d_r : tail;
    end else if (!skid_v_r) begin
      skid_d_r <= tail;
    end
  end

  assign out_valid       = out_v_r;
  assign out_red_out     = out_d_r.red;
  assign out_green_out   = out_d_r.green;
  assign out_blue_out    = out_d_r.blue;
  assign out_cone_weight = out_d_r.cone;
  assign out_lit         = out_d_r.lit;
  assign out_too_close   = out_d_r.close;

endmodule

// ===== bench/spot_checker.sv =====
`timescale 1ns / 1ps

module spot_checker
  import slt_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic signed [COORD_WIDTH_DEF-1:0] in_point_x,
  input  logic signed [COORD_WIDTH_DEF-1:0] in_point_y,
  input  logic signed [COORD_WIDTH_DEF-1:0] in_point_z,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [15:0]                     out_red_out,
  input  logic [15:0]                     out_green_out,
  input  logic [15:0]                     out_blue_out,
  input  logic [14:0]                     out_cone_weight,
  input  logic                            out_lit,
  input  logic                            out_too_close,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  cfg_idx_t                        cfg_index,
  input  logic [CFG_DATA_W-1:0]           cfg_data,
  output int                              err_count,
  output int                              pending
);

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [14:0] weight;
    logic        lit;
    logic        too_close;
  } shade_t;

  // Mirror of the light registers
  logic signed [COORD_WIDTH_DEF-1:0] lpos_x, lpos_y, lpos_z;
  logic [47:0]                       axis_q14, rgb;
  logic signed [15:0]                cone_in, cone_out;

  shade_t shade_q[$];

  // Work out the shaded color of one surface point
  function automatic shade_t shade_point(logic signed [COORD_WIDTH_DEF-1:0] px,
                                         logic signed [COORD_WIDTH_DEF-1:0] py,
                                         logic signed [COORD_WIDTH_DEF-1:0] pz);
    longint          d [3];
    longint unsigned m [3];
    longint unsigned dist_sq, len, rem, bit_v, w, num, q, col;
    longint          dot, cosv, ci, co;
    logic            close;
    shade_t          res;
    d[0] = longint'(px) - longint'(lpos_x);
    d[1] = longint'(py) - longint'(lpos_y);
    d[2] = longint'(pz) - longint'(lpos_z);
    dist_sq = 0;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = d[i] < 0 ? longint'(-d[i]) : longint'(d[i]);
      dist_sq += m[i] * m[i];
      dot += longint'($signed(axis_q14[16*i +: 16])) * d[i];
    end
    close = (dist_sq == 0);
    ci = longint'(cone_in);
    co = longint'(cone_out);
    if (close) begin
      w = ONE_Q14;
    end else begin
      // Integer square root of the squared length
      rem = dist_sq;
      len = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > rem) bit_v >>= 2;
      while (bit_v != 0) begin
        if (rem >= len + bit_v) begin
          rem -= len + bit_v;
          len = (len >> 1) + bit_v;
        end else begin
          len >>= 1;
        end
        bit_v >>= 2;
      end
      if (len == 0) len = 1;
      cosv = dot / longint'(len);
      if (cosv > ci) w = ONE_Q14;
      else if (cosv > co) w = ((cosv - co) << 14) / (ci - co);
      else w = 0;
    end
    for (int i = 0; i < 3; i++) begin
      col = rgb[16*i +: 16];
      if (close) begin
        q = col != 0 ? 16'hFFFF : 0;
      end else begin
        num = (col * w) << COLOR_SHIFT;
        q = num / dist_sq;
        if (q > 16'hFFFF) q = 16'hFFFF;
      end
      case (i)
        0: res.red = q[15:0];
        1: res.green = q[15:0];
        default: res.blue = q[15:0];
      endcase
    end
    res.weight = w[14:0];
    res.lit = (w > 0);
    res.too_close = close;
    return res;
  endfunction

  // Track register writes, predict accepted points, check delivered results
  always @(posedge clk) begin
    shade_t want;
    if (!rst_n) begin
      lpos_x <= '0;
      lpos_y <= '0;
      lpos_z <= '0;
      axis_q14 <= '0;
      cone_in <= 16'sd16384;
      cone_out <= '0;
      rgb <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LIGHT_X:     lpos_x <= cfg_data[COORD_WIDTH_DEF-1:0];
          CFG_LIGHT_Y:     lpos_y <= cfg_data[COORD_WIDTH_DEF-1:0];
          CFG_LIGHT_Z:     lpos_z <= cfg_data[COORD_WIDTH_DEF-1:0];
          CFG_SPOT_AXIS:   axis_q14 <= cfg_data;
          CFG_INNER_COS:   cone_in <= cfg_data[15:0];
          CFG_OUTER_COS:   cone_out <= cfg_data[15:0];
          CFG_LIGHT_COLOR: rgb <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        shade_q.push_back(shade_point(in_point_x, in_point_y, in_point_z));
      if (out_valid && !out_stall) begin
        if (shade_q.size() == 0) begin
          $display("%0t: result with nothing expected: r=%0d g=%0d b=%0d w=%0d",
                   $time, out_red_out, out_green_out, out_blue_out, out_cone_weight);
          err_count++;
        end else begin
          want = shade_q.pop_front();
          if (out_red_out !== want.red) begin
            $display("%0t: red expected %0d got %0d", $time, want.red, out_red_out);
            err_count++;
          end
          if (out_green_out !== want.green) begin
            $display("%0t: green expected %0d got %0d", $time, want.green, out_green_out);
            err_count++;
          end
          if (out_blue_out !== want.blue) begin
            $display("%0t: blue expected %0d got %0d", $time, want.blue, out_blue_out);
            err_count++;
          end
          if (out_cone_weight !== want.weight) begin
            $display("%0t: cone_weight expected %0d got %0d", $time, want.weight,
                     out_cone_weight);
            err_count++;
          end
          if (out_lit !== want.lit) begin
            $display("%0t: lit expected %0b got %0b", $time, want.lit, out_lit);
            err_count++;
          end
          if (out_too_close !== want.too_close) begin
            $display("%0t: too_close expected %0b got %0b", $time, want.too_close,
                     out_too_close);
            err_count++;
          end
        end
      end
    end
    pending <= shade_q.size();
  end

  initial begin
    err_count = 0;
    pending = 0;
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import slt_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 600000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic signed [CW-1:0]   in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [15:0]            out_red_out, out_green_out, out_blue_out;
  logic [14:0]            out_cone_weight;
  logic                   out_lit, out_too_close;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  cfg_idx_t               cfg_index = CFG_LIGHT_X;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     err_count, pending;

  // Idle percentages and the long hold-off request
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 0;
  int  hold_left = 0;
  int  cycles = 0;
  logic signed [CW-1:0] lx = '0, ly = '0, lz = '0;

  always #5 clk = ~clk;

  spot_light_intensity uut (.*);

  spot_checker chk (.*);

  // Receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left = 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_light(logic signed [CW-1:0] x, y, z, logic [47:0] axis,
                           logic signed [15:0] ci, co, logic [47:0] col);
    lx = x;
    ly = y;
    lz = z;
    write_reg(CFG_LIGHT_X, 48'(x));
    write_reg(CFG_LIGHT_Y, 48'(y));
    write_reg(CFG_LIGHT_Z, 48'(z));
    write_reg(CFG_SPOT_AXIS, axis);
    write_reg(CFG_INNER_COS, 48'(ci));
    write_reg(CFG_OUTER_COS, 48'(co));
    write_reg(CFG_LIGHT_COLOR, col);
  endtask

  // Offer one point, with a random idle gap ahead of it
  task automatic send_point(logic signed [CW-1:0] x, y, z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    in_valid <= 1'b1;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // Near the light most of the time, else anywhere
  task automatic send_random_point();
    int near;
    logic signed [CW-1:0] ox, oy, oz;
    near = $urandom_range(2);
    ox = CW'($urandom_range(16383)) - CW'(8192);
    oy = CW'($urandom_range(16383)) - CW'(8192);
    oz = CW'($urandom_range(16383)) - CW'(8192);
    if (near != 0)
      send_point(lx + ox, ly + oy, lz + oz);
    else
      send_point(CW'($urandom), CW'($urandom), CW'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [47:0] pack3(logic [15:0] a, b, c);
    return {c, b, a};
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: black light at origin
    send_point(0, 0, 0);
    send_point(4096, 0, 0);
    drain();

    // Axis +z, cones 20 and 30 degrees
    set_light(0, 0, 0, pack3(0, 0, 16384), 15396, 14189, pack3(16'hFFFF, 16'h8000, 1));
    send_point(0, 0, 0);
    send_point(0, 0, 4096);
    send_point(0, 0, 1);
    send_point(1731, 0, 3712);
    send_point(4096, 0, 0);
    send_point(0, 0, -4096);
    send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_point(-24'sh800000, -24'sh800000, -24'sh800000);
    send_point(0, 0, 24'sh7FFFFF);
    drain();

    // Light at an extreme corner, swapped cones, non-unit axis
    set_light(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, pack3(16'h7FFF, 16'h7FFF, 16'h7FFF),
              -16384, 16384, pack3(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_point(-24'sh800000, -24'sh800000, -24'sh800000);
    send_point(24'sh7FFFFE, 24'sh7FFFFF, 24'sh7FFFFF);
    drain();

    // Opposite corner, widest cone, negative axis
    set_light(-24'sh800000, -24'sh800000, -24'sh800000, pack3(16'h8000, 0, 0),
              16384, -16384, pack3(0, 16'h00FF, 16'hFFFF));
    send_point(-24'sh800000, -24'sh800000, -24'sh800000);
    send_point(24'sh7FFFFF, -24'sh800000, -24'sh800000);
    send_point(-24'sh800001, -24'sh800000, -24'sh800000);
    drain();

    // Random phases with random light settings and idling modes
    for (int ph = 0; ph < 6; ph++) begin
      set_light(CW'($urandom), CW'($urandom), CW'($urandom),
                (ph % 2) ? 48'({$urandom, $urandom}) : pack3(0, 11585, 11585),
                16'($urandom_range(16384)),
                16'($signed(16'($urandom_range(32768))) - 16384),
                48'({$urandom, $urandom}));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      for (int n = 0; n < 155; n++) begin
        if (ph == 0 && n == 20) hold_req = 1;
        send_random_point();
      end
      drain();
    end

    if (err_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

// ===== files.f =====
design/slt_pkg.sv
design/slt_pipe.sv
design/slt_isqrt.sv
design/slt_div.sv
design/spot_light_intensity.sv
bench/spot_checker.sv
bench/testbench.sv
